FILE: rtl/uart_pkg.sv
package uart_pkg;

    // Default build-time configuration.
    localparam int DATA_BITS_DEF   = 8;
    localparam int COUNT_WIDTH_DEF = 16;

    // Register file layout.
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 3;
    localparam int TPB_W       = 16;
    localparam logic [TPB_W-1:0] TPB_RESET = 16'd104;

    // Register index (word address) of ticks_per_bit.
    localparam logic [0:0] REG_TICKS_PER_BIT = 1'b0;

    // Frame phase shared by the transmitter and the receiver.
    // For the receiver, PH_START is the half-bit wait after the falling edge.
    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_START = 4'b0010,
        PH_DATA  = 4'b0100,
        PH_STOP  = 4'b1000
    } t_phase;

    // One input item: one tick of the baud timing.
    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_byte;
        logic       rx_line;
    } t_in_item;

    // One result item for that tick.
    typedef struct packed {
        logic       tx_line;
        logic       tx_busy;
        logic       send_taken;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       rx_busy;
    } t_out_item;

    // Status from the transmitter for one tick.
    typedef struct packed {
        logic line;
        logic busy;
        logic taken;
    } t_tx_res;

    // Status from the receiver for one tick.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       busy;
    } t_rx_res;

endpackage

FILE: rtl/uart_cfg.sv
module uart_cfg #(
    parameter int COUNT_WIDTH = uart_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [uart_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [uart_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [uart_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    output logic [COUNT_WIDTH-1:0]          o_period,
    output logic [COUNT_WIDTH-1:0]          o_half
);

    logic [uart_pkg::TPB_W-1:0] r_tpb;
    logic [uart_pkg::TPB_W-1:0] n_tpb;
    logic                       reg_hit;
    logic                       wr_en;

    // Limit a bit period to what the tick counter can reach, and to at least one tick.
    function automatic logic [COUNT_WIDTH-1:0] clamp_period(input logic [uart_pkg::TPB_W-1:0] v);
        logic [31:0] wide;
        logic [31:0] lim;
        lim  = (32'd1 << COUNT_WIDTH) - 32'd1;
        wide = {16'd0, v};
        if (wide > lim) begin
            wide = lim;
        end
        if (wide == 32'd0) begin
            wide = 32'd1;
        end
        return wide[COUNT_WIDTH-1:0];
    endfunction

    // Address decode; the port never inserts wait states.
    assign reg_hit = (paddr[uart_pkg::CFG_ADDR_W-1:2] == uart_pkg::REG_TICKS_PER_BIT);
    assign wr_en   = psel && penable && pwrite && reg_hit;
    assign pready  = 1'b1;

    always_comb begin
        n_tpb = r_tpb;
        if (wr_en) begin
            n_tpb = pwdata[uart_pkg::TPB_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpb <= uart_pkg::TPB_RESET;
        end else begin
            r_tpb <= n_tpb;
        end
    end

    // Read back the raw register value.
    always_comb begin
        prdata = '0;
        if (reg_hit) begin
            prdata = {{(uart_pkg::CFG_DATA_W - uart_pkg::TPB_W){1'b0}}, r_tpb};
        end
    end

    // Full and half bit periods as used by the tick counters.
    assign o_period = clamp_period(r_tpb);
    assign o_half   = clamp_period(r_tpb >> 1);

endmodule

FILE: rtl/uart_tx.sv
module uart_tx #(
    parameter int DATA_BITS   = uart_pkg::DATA_BITS_DEF,
    parameter int COUNT_WIDTH = uart_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_send_valid,
    input  logic [7:0]             i_send_byte,
    input  logic [COUNT_WIDTH-1:0] i_period,
    output uart_pkg::t_tx_res      o_res
);

    localparam int IDX_W = $clog2(DATA_BITS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DATA_BITS - 1);

    uart_pkg::t_phase       r_phase, n_phase;
    logic [DATA_BITS-1:0]   r_shift, n_shift;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;
    logic [COUNT_WIDTH-1:0] cnt_inc;

    always_comb begin
        n_phase     = r_phase;
        n_shift     = r_shift;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        o_res.taken = 1'b0;

        // A request is taken only while idle; the frame starts this tick.
        if (r_phase == uart_pkg::PH_IDLE && i_send_valid) begin
            n_shift     = i_send_byte[DATA_BITS-1:0];
            n_phase     = uart_pkg::PH_START;
            n_idx       = '0;
            n_cnt       = '0;
            o_res.taken = 1'b1;
        end

        // Line level for this tick.
        case (n_phase)
            uart_pkg::PH_START: o_res.line = 1'b0;
            uart_pkg::PH_DATA:  o_res.line = n_shift[n_idx];
            default:            o_res.line = 1'b1;
        endcase
        o_res.busy = (n_phase != uart_pkg::PH_IDLE);

        // Bit timing and phase advance.
        cnt_inc = n_cnt + COUNT_WIDTH'(1);
        if (o_res.busy) begin
            if (cnt_inc >= i_period) begin
                n_cnt = '0;
                case (n_phase)
                    uart_pkg::PH_START: begin
                        n_phase = uart_pkg::PH_DATA;
                        n_idx   = '0;
                    end
                    uart_pkg::PH_DATA: begin
                        if (n_idx == LAST_IDX) begin
                            n_phase = uart_pkg::PH_STOP;
                        end else begin
                            n_idx = n_idx + IDX_W'(1);
                        end
                    end
                    default: begin
                        n_phase = uart_pkg::PH_IDLE;
                    end
                endcase
            end else begin
                n_cnt = cnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= uart_pkg::PH_IDLE;
            r_shift <= '0;
            r_idx   <= '0;
            r_cnt   <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_shift <= n_shift;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
        end
    end

endmodule

FILE: rtl/uart_rx.sv
module uart_rx #(
    parameter int DATA_BITS   = uart_pkg::DATA_BITS_DEF,
    parameter int COUNT_WIDTH = uart_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_rx_line,
    input  logic [COUNT_WIDTH-1:0] i_period,
    input  logic [COUNT_WIDTH-1:0] i_half,
    output uart_pkg::t_rx_res      o_res
);

    localparam int IDX_W = $clog2(DATA_BITS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DATA_BITS - 1);

    uart_pkg::t_phase       r_phase, n_phase;
    logic [DATA_BITS-1:0]   r_shift, n_shift;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;
    logic [COUNT_WIDTH-1:0] cnt_inc;

    always_comb begin
        n_phase     = r_phase;
        n_shift     = r_shift;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        o_res.valid = 1'b0;
        o_res.data  = '0;
        cnt_inc     = r_cnt + COUNT_WIDTH'(1);

        case (r_phase)
            // A low line opens a frame.
            uart_pkg::PH_IDLE: begin
                if (!i_rx_line) begin
                    n_phase = uart_pkg::PH_START;
                    n_shift = '0;
                    n_idx   = '0;
                    n_cnt   = '0;
                end
            end
            // Half-bit wait to move the sample point to mid-bit.
            uart_pkg::PH_START: begin
                if (cnt_inc >= i_half) begin
                    n_phase = uart_pkg::PH_DATA;
                    n_cnt   = '0;
                end else begin
                    n_cnt = cnt_inc;
                end
            end
            // Sample one data bit per bit period, LSB first.
            uart_pkg::PH_DATA: begin
                if (cnt_inc >= i_period) begin
                    n_cnt          = '0;
                    n_shift[r_idx] = r_shift[r_idx] | i_rx_line;
                    if (r_idx == LAST_IDX) begin
                        n_phase = uart_pkg::PH_STOP;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end else begin
                    n_cnt = cnt_inc;
                end
            end
            // Wait out the stop bit without checking it, then report.
            default: begin
                if (cnt_inc >= i_period) begin
                    n_cnt       = '0;
                    n_phase     = uart_pkg::PH_IDLE;
                    o_res.valid = 1'b1;
                    o_res.data  = 8'(r_shift);
                end else begin
                    n_cnt = cnt_inc;
                end
            end
        endcase

        o_res.busy = (n_phase != uart_pkg::PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= uart_pkg::PH_IDLE;
            r_shift <= '0;
            r_idx   <= '0;
            r_cnt   <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_shift <= n_shift;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
        end
    end

endmodule

FILE: rtl/uart_skid.sv
module uart_skid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  uart_pkg::t_out_item i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output uart_pkg::t_out_item o_data
);

    logic                r_out_valid, n_out_valid;
    logic                r_skid_valid, n_skid_valid;
    uart_pkg::t_out_item r_out_data, n_out_data;
    uart_pkg::t_out_item r_skid_data, n_skid_data;
    logic                push;
    logic                pop;

    // Space is left as long as the skid entry is empty.
    assign o_ready = !r_skid_valid;
    assign push    = i_valid && o_ready;
    assign pop     = r_out_valid && i_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (!r_out_valid || pop) begin
            // Output register is free: refill from the skid entry first.
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else if (push) begin
                n_out_valid = 1'b1;
                n_out_data  = i_data;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (push) begin
            // Output is held by a stalled transfer: park the new result.
            n_skid_valid = 1'b1;
            n_skid_data  = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

FILE: rtl/uart_8n1_transceiver.sv
// Bit-level 8N1 UART transmitter and receiver. Every input transfer is one baud tick carrying
// the sampled receive line and an optional byte to send; every tick yields exactly one result
// transfer with the transmit line level, busy flags, a send-taken flag and any received byte.
// A send request is taken only while the transmitter is idle and is otherwise dropped. Each bit
// lasts ticks_per_bit ticks (register at byte address 0, reset 104, 0 acts as 1, clamped to the
// tick counter range). The receiver starts on a low line, waits half a bit, samples DATA_BITS
// bits at mid-bit LSB first, waits one bit period for the unchecked stop bit, then reports.
// Each tick is handled by the frame state registers, so one tick is accepted every clock while
// input ready is high; the two-entry output buffer keeps input ready high until two results
// are waiting unread. Each result is registered in the output buffer before it is offered.
module uart_8n1_transceiver #(
    parameter int DATA_BITS   = uart_pkg::DATA_BITS_DEF,
    parameter int COUNT_WIDTH = uart_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Tick input
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  uart_pkg::t_in_item              i_in_data,
    // Result output
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output uart_pkg::t_out_item             o_out_data,
    // Register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [uart_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [uart_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [uart_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);

    logic                   in_accept;
    logic [COUNT_WIDTH-1:0] period;
    logic [COUNT_WIDTH-1:0] half;
    uart_pkg::t_tx_res      tx_res;
    uart_pkg::t_rx_res      rx_res;
    uart_pkg::t_out_item    result;

    assign in_accept = i_in_valid && o_in_ready;

    // Configuration register.
    uart_cfg #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_period (period),
        .o_half   (half)
    );

    // Transmitter; its state advances once per accepted tick.
    uart_tx #(
        .DATA_BITS   (DATA_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_tx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (in_accept),
        .i_send_valid (i_in_data.send_valid),
        .i_send_byte  (i_in_data.send_byte),
        .i_period     (period),
        .o_res        (tx_res)
    );

    // Receiver.
    uart_rx #(
        .DATA_BITS   (DATA_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_rx (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (in_accept),
        .i_rx_line (i_in_data.rx_line),
        .i_period  (period),
        .i_half    (half),
        .o_res     (rx_res)
    );

    // Assemble this tick's result.
    always_comb begin
        result.tx_line    = tx_res.line;
        result.tx_busy    = tx_res.busy;
        result.send_taken = tx_res.taken;
        result.rx_valid   = rx_res.valid;
        result.rx_byte    = rx_res.data;
        result.rx_busy    = rx_res.busy;
    end

    // Output register with skid entry.
    uart_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_accept),
        .o_ready (o_in_ready),
        .i_data  (result),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

`ifndef ASSERT_OFF
    // Input back-pressure only happens with a result waiting at the output.
    a_ready_implies_pending: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid
    ) else $error("input stalled with no result pending");

    // A completed byte ends the receive frame.
    a_rx_done_not_busy: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.rx_valid |-> !o_out_data.rx_busy
    ) else $error("receiver still busy on its report tick");

    // A taken request starts the frame with the start bit.
    a_taken_starts_frame: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.send_taken |-> o_out_data.tx_busy && !o_out_data.tx_line
    ) else $error("taken send did not drive a start bit");

    // The transmit line idles high.
    a_tx_idle_high: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.tx_busy |-> o_out_data.tx_line
    ) else $error("transmit line low while idle");
`endif

endmodule

FILE: tb/uart_8n1_transceiver_checker.sv
`timescale 1ns / 1ps

// Watches the tick and result channels and the register port of the UART transceiver.
// It keeps its own copy of the transmitter and receiver frame state, works out the result
// of every accepted tick and compares each accepted result with the oldest one waiting.
module uart_8n1_transceiver_checker
    import uart_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_item              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_item             i_out_data,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [CFG_ADDR_W-1:0] i_paddr,
    input  logic [CFG_DATA_W-1:0] i_pwdata,
    input  logic [CFG_DATA_W-1:0] i_prdata,
    input  logic                  i_pready,
    output int                    o_mismatches,
    output int                    o_pending
);

    localparam logic [CFG_ADDR_W-1:0] TPB_ADDR = CFG_ADDR_W'(4 * int'(REG_TICKS_PER_BIT));
    localparam logic [2:0] LAST_BIT = 3'(DATA_BITS_DEF - 1);

    // Predicted configuration and frame state.
    logic [TPB_W-1:0]           ticks_per_bit;
    t_phase                     tx_phase;
    t_phase                     rx_phase;
    logic [7:0]                 tx_shift;
    logic [7:0]                 rx_shift;
    logic [2:0]                 tx_bit;
    logic [2:0]                 rx_bit;
    logic [COUNT_WIDTH_DEF-1:0] tx_count;
    logic [COUNT_WIDTH_DEF-1:0] rx_count;

    // Tick results still owed by the block, oldest first.
    t_out_item tick_results_q[$];
    int        result_count;
    int        mismatch_count;
    int        pending;

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("[%0t] result %0d: %s: got %0h, expected %0h",
                 $time, result_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) begin
            report_mismatch(what, 16'(got), 16'(want));
        end
    endtask

    // Advances the transmitter and receiver by one tick and returns the result of that tick.
    task automatic predict_tick(input t_in_item item, output t_out_item res);
        logic [COUNT_WIDTH_DEF-1:0] period;
        logic [COUNT_WIDTH_DEF-1:0] half_period;
        period      = (ticks_per_bit == '0) ? COUNT_WIDTH_DEF'(1) : ticks_per_bit;
        half_period = ((ticks_per_bit >> 1) == '0) ? COUNT_WIDTH_DEF'(1)
                                                   : (ticks_per_bit >> 1);
        res         = '0;
        res.tx_line = 1'b1;

        // A send request is taken only while the transmitter is idle.
        if (tx_phase == PH_IDLE && item.send_valid) begin
            tx_shift       = item.send_byte;
            tx_phase       = PH_START;
            tx_bit         = '0;
            tx_count       = '0;
            res.send_taken = 1'b1;
        end
        if (tx_phase == PH_START) begin
            res.tx_line = 1'b0;
        end else if (tx_phase == PH_DATA) begin
            res.tx_line = tx_shift[tx_bit];
        end
        res.tx_busy = (tx_phase != PH_IDLE);
        if (res.tx_busy) begin
            tx_count = tx_count + 1'b1;
            if (tx_count >= period) begin
                tx_count = '0;
                case (tx_phase)
                    PH_START: begin
                        tx_phase = PH_DATA;
                        tx_bit   = '0;
                    end
                    PH_DATA: begin
                        if (tx_bit >= LAST_BIT) begin
                            tx_phase = PH_STOP;
                        end else begin
                            tx_bit = tx_bit + 1'b1;
                        end
                    end
                    default: begin
                        tx_phase = PH_IDLE;
                    end
                endcase
            end
        end

        // The receiver leaves idle on a low line, waits half a bit, then samples each bit
        // one full period apart and reports after one more period without a stop check.
        if (rx_phase == PH_IDLE) begin
            if (!item.rx_line) begin
                rx_phase = PH_START;
                rx_shift = '0;
                rx_bit   = '0;
                rx_count = '0;
            end
        end else begin
            rx_count = rx_count + 1'b1;
            case (rx_phase)
                PH_START: begin
                    if (rx_count >= half_period) begin
                        rx_phase = PH_DATA;
                        rx_count = '0;
                    end
                end
                PH_DATA: begin
                    if (rx_count >= period) begin
                        rx_count         = '0;
                        rx_shift[rx_bit] = item.rx_line;
                        if (rx_bit >= LAST_BIT) begin
                            rx_phase = PH_STOP;
                        end else begin
                            rx_bit = rx_bit + 1'b1;
                        end
                    end
                end
                default: begin
                    if (rx_count >= period) begin
                        rx_count     = '0;
                        res.rx_valid = 1'b1;
                        res.rx_byte  = rx_shift;
                        rx_phase     = PH_IDLE;
                    end
                end
            endcase
        end
        res.rx_busy = (rx_phase != PH_IDLE);
    endtask

    always @(posedge i_clk) begin : watch_transfers
        t_out_item want;
        t_out_item fresh;
        if (!i_rst_n) begin
            ticks_per_bit  = TPB_RESET;
            tx_phase       = PH_IDLE;
            rx_phase       = PH_IDLE;
            tx_shift       = '0;
            rx_shift       = '0;
            tx_bit         = '0;
            rx_bit         = '0;
            tx_count       = '0;
            rx_count       = '0;
            result_count   = 0;
            mismatch_count = 0;
            tick_results_q.delete();
        end else begin
            // Register port: track writes and check read data.
            if (i_psel && i_penable && i_pready && i_paddr == TPB_ADDR) begin
                if (i_pwrite) begin
                    ticks_per_bit = i_pwdata[TPB_W-1:0];
                end else if (i_prdata[TPB_W-1:0] !== ticks_per_bit) begin
                    report_mismatch("ticks_per_bit readback", i_prdata[TPB_W-1:0],
                                    ticks_per_bit);
                end
            end

            // Result transfer: compare with the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                if (tick_results_q.size() == 0) begin
                    report_mismatch("result with no tick waiting", 16'(i_out_data), '0);
                end else begin
                    want = tick_results_q.pop_front();
                    check_field("tx_line", 8'(i_out_data.tx_line), 8'(want.tx_line));
                    check_field("tx_busy", 8'(i_out_data.tx_busy), 8'(want.tx_busy));
                    check_field("send_taken", 8'(i_out_data.send_taken),
                                8'(want.send_taken));
                    check_field("rx_valid", 8'(i_out_data.rx_valid), 8'(want.rx_valid));
                    check_field("rx_byte", i_out_data.rx_byte, want.rx_byte);
                    check_field("rx_busy", 8'(i_out_data.rx_busy), 8'(want.rx_busy));
                end
                result_count++;
            end

            // Tick transfer: predict its result.
            if (i_in_valid && i_in_ready) begin
                predict_tick(i_in_data, fresh);
                tick_results_q.push_back(fresh);
            end
        end
        pending <= tick_results_q.size();
    end

endmodule

FILE: tb/uart_8n1_transceiver_tb.sv
`timescale 1ns / 1ps

module uart_8n1_transceiver_tb;
    import uart_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] TPB_ADDR = CFG_ADDR_W'(4 * int'(REG_TICKS_PER_BIT));
    localparam int MAX_FRAME_BIT   = 128;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int PHASE_TICKS     = 56;
    localparam int RESET_TICKS     = 300;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_item             o_out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int   mismatches;
    int   pending;
    logic gaps_on;
    logic hold_off_req;

    // Receive line levels still to be played, one per tick.
    logic rx_levels[$];

    uart_8n1_transceiver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    uart_8n1_transceiver_checker tick_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    // Hard stop in case the block hangs.
    initial begin
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: random stalls, and one long hold-off on request.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                i_out_ready <= !(gaps_on && $urandom_range(99) < 10);
            end
        end
    end

    // Offers one tick and returns at the edge where its transfer happens.
    task automatic push_tick(input t_in_item item);
        if (gaps_on && $urandom_range(99) < 10) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Stops offering ticks until every tick result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_transfer(input logic is_write, input logic [CFG_ADDR_W-1:0] addr,
                                input logic [CFG_DATA_W-1:0] wdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Start bit, eight data bits LSB first, then a stop level of the given length.
    task automatic push_rx_frame(input logic [7:0] value, input int len, input int stop_len);
        repeat (len) rx_levels.push_back(1'b0);
        for (int b = 0; b < 8; b++) begin
            repeat (len) rx_levels.push_back(value[b]);
        end
        repeat (stop_len) rx_levels.push_back(1'b1);
    endtask

    // Mostly well-formed frames with random bytes, the rest glitches and noise.
    task automatic plan_rx_traffic(input int bit_len);
        int kind;
        int len;
        int stop_len;
        kind = $urandom_range(99);
        if (kind < 75) begin
            len      = bit_len + (($urandom_range(9) == 0) ? 1 : 0);
            stop_len = ($urandom_range(3) == 0) ? $urandom_range(0, len) : len;
            push_rx_frame(8'($urandom), len, stop_len);
            repeat ($urandom_range(0, 2 * bit_len)) rx_levels.push_back(1'b1);
        end else if (kind < 87) begin
            repeat ($urandom_range(1, bit_len)) rx_levels.push_back(1'b0);
            repeat ($urandom_range(1, 2 * bit_len)) rx_levels.push_back(1'b1);
        end else begin
            repeat ($urandom_range(1, 8)) rx_levels.push_back(1'($urandom_range(1)));
        end
    endtask

    // Random ticks: receive traffic from the planner, random send requests.
    task automatic run_phase(input int n_ticks, input int bit_len, input int send_pct,
                             input int hold_at);
        t_in_item item;
        for (int k = 0; k < n_ticks; k++) begin
            if (k == hold_at) begin
                hold_off_req = 1'b1;
            end
            if (rx_levels.size() == 0) begin
                plan_rx_traffic(bit_len);
            end
            item.rx_line    = rx_levels.pop_front();
            item.send_valid = ($urandom_range(99) < send_pct);
            item.send_byte  = 8'($urandom);
            push_tick(item);
        end
    endtask

    initial begin
        t_in_item    item;
        int unsigned tpb;
        int          bit_len;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        gaps_on      = 1'b0;
        hold_off_req = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset value of the bit period, the opening bits of frames at that period, no idling.
        apb_transfer(1'b0, TPB_ADDR, '0);
        run_phase(RESET_TICKS, int'(TPB_RESET), 25, -1);
        drain_results();
        gaps_on = 1'b1;

        // Bit period of zero acts as one. A send of all ones, then requests of zero while
        // busy; receive frames of all zeros and all ones, the second starting on the tick
        // right after the first is reported.
        apb_transfer(1'b1, TPB_ADDR, '0);
        apb_transfer(1'b0, TPB_ADDR, '0);
        rx_levels.delete();
        push_rx_frame(8'h00, 1, 1);
        rx_levels.push_back(1'b1);
        push_rx_frame(8'hFF, 1, 2);
        for (int k = 0; k < 24; k++) begin
            item.send_valid = 1'b1;
            item.send_byte  = (k == 0) ? 8'hFF : 8'h00;
            item.rx_line    = (rx_levels.size() != 0) ? rx_levels.pop_front() : 1'b1;
            push_tick(item);
        end
        drain_results();

        // Random phases over several bit periods, the extremes among them.
        for (int p = 0; p < 12; p++) begin
            case (p)
                0: tpb = 2;
                1: tpb = 3;
                2: tpb = 1;
                3: tpb = 65535;
                4: tpb = 2;
                default: tpb = $urandom_range(2, 5);
            endcase
            gaps_on = (p != 2);
            apb_transfer(1'b1, TPB_ADDR, {16'($urandom), 16'(tpb)});
            apb_transfer(1'b0, TPB_ADDR, '0);
            bit_len = (tpb == 0) ? 1 : ((tpb > MAX_FRAME_BIT) ? MAX_FRAME_BIT : int'(tpb));
            rx_levels.delete();
            run_phase(PHASE_TICKS, bit_len, 30, (p == 5) ? 30 : -1);
            drain_results();
        end

        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
